FILE: rtl/br1u_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br1u_pkg - shared types and constants of the ByteRun1 row unpacker
// Register indexes, compression codes, field widths and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package br1u_pkg;

  localparam int MAX_ROW_BYTES_DEF = 512;
  localparam int MAX_ROWS_DEF      = 8192;

  localparam int COMPRESSION_W = 8;
  localparam int ROW_BYTES_W   = 10;
  localparam int ROWS_TOTAL_W  = 14;
  localparam int CFG_DATA_W    = 14;
  localparam int CFG_INDEX_W   = 2;
  localparam int RUN_W         = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_TOTAL  = 2'd2;

  localparam logic [COMPRESSION_W-1:0] CMP_NONE      = 8'd0;
  localparam logic [COMPRESSION_W-1:0] CMP_BYTERUN1  = 8'd1;

  // -128 header: no-op
  localparam logic [7:0] HDR_NOP = 8'h80;

  localparam logic [COMPRESSION_W-1:0] RST_COMPRESSION = CMP_NONE;
  localparam logic [ROW_BYTES_W-1:0]   RST_ROW_BYTES   = 10'd40;
  localparam logic [ROWS_TOTAL_W-1:0]  RST_ROWS_TOTAL  = 14'd200;

  typedef struct packed {
    logic step_byte;    // process the accepted input byte
    logic step_expand;  // emit the next chunk of a repeat run
    logic expand_mode;  // controller is expanding a repeat run
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic start_expand; // current byte is a repeat data byte
    logic run_done;     // current chunk finishes the repeat run
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/br1u_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br1u_ctrl - sequencer of the row unpacker
// Takes bytes while idle and the result register is free, and holds the
// input off while a repeat run is expanded up to two bytes per result.
// ----------------------------------------------------------------------------
module br1u_ctrl
  import br1u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXPAND
  } state_t;

  state_t state;

  always_comb begin
    in_ready        = (state == S_IDLE) && sts.out_free;
    cmd.expand_mode = (state == S_EXPAND);
    cmd.step_byte   = in_valid && in_ready;
    cmd.step_expand = (state == S_EXPAND) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.step_byte && sts.start_expand) begin
            state <= S_EXPAND;
          end
        end
        S_EXPAND: begin
          if (cmd.step_expand && sts.run_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/br1u_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// br1u_dpath - decode datapath of the row unpacker
// Config registers, decode state, row and run counters, and the result
// register.
// ----------------------------------------------------------------------------
module br1u_dpath
  import br1u_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   source_end,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  sts,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  byte_first,
  output logic [7:0]                  byte_second,
  output logic [1:0]                  byte_count,
  output logic                        row_end,
  output logic                        image_done,
  output logic                        run_last,
  output logic                        decode_error
);

  localparam int RL_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int RD_W = $clog2(MAX_ROWS + 1);
  localparam int BW   = (RL_W > ROW_BYTES_W) ? RL_W : ROW_BYTES_W;
  localparam int RW   = (RD_W > ROWS_TOTAL_W) ? RD_W : ROWS_TOTAL_W;
  localparam int LW   = (RL_W > RUN_W + 1) ? RL_W : RUN_W + 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT
  } phase_t;

  // configuration
  logic [COMPRESSION_W-1:0] compression;
  logic [ROW_BYTES_W-1:0]   row_bytes;
  logic [ROWS_TOTAL_W-1:0]  rows_total;

  // decode state
  phase_t            phase, phase_next;
  logic [RUN_W-1:0]  run_left, run_left_next;
  logic [RL_W-1:0]   row_left, row_left_next;
  logic [RD_W-1:0]   rows_done, rows_done_next;
  logic              err, err_next;
  logic              fin, fin_next;
  logic [7:0]        hold_byte;
  logic              hold_last;

  // step signals
  logic [RW-1:0]     rt_eff;
  logic [BW-1:0]     rb_eff;
  logic              rows_empty;
  logic [RL_W-1:0]   rl_cur, rl_after;
  logic [RUN_W-1:0]  run_len, run_rem;
  logic [1:0]        req, cnt;
  logic              emit, final_step, new_err, rend, done, last_in;
  logic [7:0]        emit_byte;
  logic              has_result;

  always_comb begin
    rt_eff = (RW'(rows_total) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_total);
    rb_eff = (BW'(row_bytes) > BW'(MAX_ROW_BYTES)) ? BW'(MAX_ROW_BYTES) : BW'(row_bytes);
    rows_empty = (rt_eff == '0) || (RW'(rows_done) >= rt_eff);
  end

  always_comb begin
    phase_next       = phase;
    run_left_next    = run_left;
    row_left_next    = row_left;
    rows_done_next   = rows_done;
    err_next         = err;
    fin_next         = fin;
    rl_cur           = row_left;
    run_len          = '0;
    run_rem          = '0;
    req              = 2'd0;
    emit             = 1'b0;
    final_step       = 1'b0;
    new_err          = 1'b0;
    sts.out_free     = !out_valid || out_ready;
    sts.start_expand = 1'b0;
    sts.run_done     = 1'b0;
    emit_byte        = cmd.expand_mode ? hold_byte : data_byte;
    last_in          = cmd.expand_mode ? hold_last : source_end;

    if (!cmd.expand_mode) begin
      if (err || fin) begin
        // stream over: byte dropped
      end else if (rows_empty) begin
        fin_next = 1'b1;
      end else if (compression > CMP_BYTERUN1) begin
        new_err    = 1'b1;
        final_step = 1'b1;
      end else if (rb_eff == '0) begin
        fin_next = 1'b1;
      end else begin
        rl_cur        = (row_left == '0) ? rb_eff[RL_W-1:0] : row_left;
        row_left_next = rl_cur;
        final_step    = 1'b1;
        if (compression == CMP_NONE) begin
          phase_next = PH_HEADER;
          emit       = 1'b1;
          req        = 2'd1;
        end else begin
          unique case (phase)
            PH_HEADER: begin
              if (!data_byte[7]) begin
                run_len = {1'b0, data_byte[6:0]} + RUN_W'(1);
              end else begin
                run_len = RUN_W'(9'd257 - {1'b0, data_byte});
              end
              if (data_byte != HDR_NOP) begin
                if (LW'(run_len) > LW'(rl_cur)) begin
                  new_err = 1'b1;
                end else begin
                  phase_next    = data_byte[7] ? PH_REPEAT : PH_LITERAL;
                  run_left_next = run_len;
                end
              end
            end
            PH_LITERAL: begin
              emit          = 1'b1;
              req           = 2'd1;
              run_rem       = (run_left != '0) ? run_left - RUN_W'(1) : '0;
              run_left_next = run_rem;
              if (run_rem == '0) begin
                phase_next = PH_HEADER;
              end
            end
            PH_REPEAT: begin
              final_step       = 1'b0;
              sts.start_expand = 1'b1;
            end
            default: phase_next = PH_HEADER;
          endcase
        end
      end
    end else begin
      emit          = 1'b1;
      req           = (run_left >= RUN_W'(2)) ? 2'd2 : 2'd1;
      run_rem       = run_left - RUN_W'(req);
      run_left_next = run_rem;
      if (run_rem == '0) begin
        phase_next   = PH_HEADER;
        final_step   = 1'b1;
        sts.run_done = 1'b1;
      end
    end

    // row bookkeeping for emitted bytes
    cnt      = (LW'(req) > LW'(rl_cur)) ? rl_cur[1:0] : req;
    rl_after = rl_cur - RL_W'(cnt);
    rend     = emit && (cnt != 2'd0) && (rl_after == '0);
    done     = rend && ((RW'(rows_done) + RW'(1)) >= rt_eff);
    if (emit) begin
      row_left_next = rl_after;
    end
    if (rend) begin
      rows_done_next = rows_done + RD_W'(1);
    end
    if (done) begin
      fin_next = 1'b1;
    end

    // early end of source
    if (final_step && !new_err && last_in && !(fin || done)) begin
      new_err = 1'b1;
    end
    if (new_err) begin
      err_next = 1'b1;
    end
    has_result = emit || new_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compression <= RST_COMPRESSION;
      row_bytes   <= RST_ROW_BYTES;
      rows_total  <= RST_ROWS_TOTAL;
      phase       <= PH_HEADER;
      run_left    <= '0;
      row_left    <= '0;
      rows_done   <= '0;
      err         <= 1'b0;
      fin         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COMPRESSION: compression <= cfg_data[COMPRESSION_W-1:0];
          CFG_ROW_BYTES:   row_bytes   <= cfg_data[ROW_BYTES_W-1:0];
          CFG_ROWS_TOTAL:  rows_total  <= cfg_data[ROWS_TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step_byte || cmd.step_expand) begin
        phase     <= phase_next;
        run_left  <= run_left_next;
        row_left  <= row_left_next;
        rows_done <= rows_done_next;
        err       <= err_next;
        fin       <= fin_next;
      end
      if ((cmd.step_byte || cmd.step_expand) && has_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.step_byte) begin
      hold_byte <= data_byte;
      hold_last <= source_end;
    end
    if ((cmd.step_byte || cmd.step_expand) && has_result) begin
      byte_first   <= (cnt != 2'd0) ? emit_byte : 8'd0;
      byte_second  <= (cnt == 2'd2) ? emit_byte : 8'd0;
      byte_count   <= cnt;
      row_end      <= rend;
      image_done   <= done;
      run_last     <= final_step;
      decode_error <= new_err;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/byterun1_row_unpacker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byterun1_row_unpacker_core - ByteRun1 (PackBits) plane row unpacker
// Takes a compressed image body one byte per transaction and returns the
// decoded plane row bytes, up to two per result transaction.
// ----------------------------------------------------------------------------
// Timing: a pass-through or literal byte shows its result in the cycle after
//   the input transaction; headers give no result unless they fault.
// Throughput: one byte per cycle while the result register drains; a repeat
//   data byte is taken in a setup step, then expanded up to two bytes per
//   result, and holds the input off meanwhile.
// Reset (rst, synchronous): registers back to compression 0, row_bytes 40,
//   rows_total 200; decoder waits for a header, error and done flags clear.
// ----------------------------------------------------------------------------
module byterun1_row_unpacker_core
  import br1u_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // compressed byte stream
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   source_end,
  // decoded row bytes
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  byte_first,
  output logic [7:0]                  byte_second,
  output logic [1:0]                  byte_count,
  output logic                        row_end,
  output logic                        image_done,
  output logic                        run_last,
  output logic                        decode_error
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer: idle / expanding a repeat run. Input is taken only while
  // idle and the result register is free (or draining this cycle).
  br1u_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: config registers, header decode, row/run counters, sticky
  // error and finish flags, and the registered result.
  br1u_dpath #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .source_end   (source_end),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_first   (byte_first),
    .byte_second  (byte_second),
    .byte_count   (byte_count),
    .row_end      (row_end),
    .image_done   (image_done),
    .run_last     (run_last),
    .decode_error (decode_error)
  );

  // A repeat data byte must hold off further input on the next cycle.
  a_expand_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_byte && sts.start_expand) |=> !in_ready)
    else $error("input taken while a repeat run expands");

  // An error closes the stream: it is always the last result of its byte.
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && decode_error) |-> run_last)
    else $error("error result not marked last");

  // Image completion only ever comes with the end of a non-empty row.
  a_done_ends_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_done) |-> (row_end && byte_count != 2'd0))
    else $error("image done without row end");

endmodule

`default_nettype wire
